[src/rgs_pkg.sv]
// ----------------------------------------------------------------------------
// rgs_pkg - shared types and codes for the region growing segmenter
// Action codes, register indexes, the done direction code and sequencer states.
// ----------------------------------------------------------------------------
package rgs_pkg;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_CLICK = 2'd1;
  localparam logic [1:0] ACT_CHECK = 2'd2;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // direction code 4 marks a fully explored stack entry
  localparam logic [2:0] DIR_DONE = 3'd4;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SEED,
    S_CONQ,
    S_STEP,
    S_POP,
    S_NB_EV,
    S_FIT1,
    S_FIT2,
    S_FIT3,
    S_CK_CTR,
    S_CK_RD,
    S_CK_EV
  } state_t;

endpackage

[src/region_growing_segmenter.sv]
// ----------------------------------------------------------------------------
// region_growing_segmenter - seeded region growing over a stored image
// Loads pixels, grows labelled regions from seed clicks, answers boundary
// checks. One shared multiplier under a small sequencer does the fit test.
// ----------------------------------------------------------------------------
// User notes: after reset the label memory is swept to zero, one entry per
// cycle, with busy high (register writes still land). An item is taken
// when start is high and busy is low; every item yields exactly one result
// beat, shown for one cycle with out_valid high, and the receiver cannot
// stall it. A load leaves busy low and lets the next item in right away. A
// check does one label read of the center and one per in-bounds neighbour,
// each read being a registered single-port access. A click reads and tests
// its seed, then labels and pushes each conquered pixel in S_CONQ. Each of
// a pixel's four directions is a step in S_STEP; a neighbour inside the
// image adds a label/pixel read evaluated in S_NB_EV, and an unlabelled one
// adds S_FIT1, S_FIT2 and S_FIT3 through the shared multiplier (p*count,
// then criterion*count). Finishing a pixel takes its last step and the
// stack pop, the seed only its last step. The walk order is depth first,
// up, right, down, left.
// ----------------------------------------------------------------------------
module region_growing_segmenter #(
  parameter int MAX_ROWS   = 128,
  parameter int MAX_COLS   = 128,
  parameter int MAX_CLICKS = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [6:0]  in_row,
  input  logic [6:0]  in_col,
  input  logic [7:0]  in_pixel_value,
  input  logic [7:0]  in_criterion,
  // result channel
  output logic        out_valid,
  output logic        out_boundary,
  output logic [14:0] out_region_size,
  output logic [7:0]  out_region_label,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int LW    = $clog2(MAX_CLICKS + 1);
  localparam int NW    = $clog2(CELLS + 1);   // pixel count
  localparam int SW    = NW + 8;              // pixel sum and products
  localparam int EW    = RW + CW + 3;         // stack entry: row, col, dir
  localparam logic [7:0] ROWS_RST = (MAX_ROWS < 128) ? 8'(MAX_ROWS) : 8'd128;
  localparam logic [7:0] COLS_RST = (MAX_COLS < 128) ? 8'(MAX_COLS) : 8'd128;

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  rgs_pkg::state_t state_r, state_nxt;
  logic [7:0]    rows_r, rows_nxt, cols_r, cols_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [LW-1:0] click_r, click_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [SW-1:0] prod_r, prod_nxt;
  logic [SW-1:0] absd_r, absd_nxt;
  logic [7:0]    crit_r, crit_nxt;
  logic [AW:0]   depth_r, depth_nxt;
  logic          top_vld_r, top_vld_nxt;
  logic [RW-1:0] top_row_r, top_row_nxt, tgt_row_r, tgt_row_nxt;
  logic [CW-1:0] top_col_r, top_col_nxt, tgt_col_r, tgt_col_nxt;
  logic [2:0]    top_dir_r, top_dir_nxt;
  logic [LW-1:0] ctr_lab_r, ctr_lab_nxt;
  logic          bnd_r, bnd_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_bnd_r, out_bnd_nxt;
  logic [14:0]   out_size_r, out_size_nxt;
  logic [7:0]    out_lab_r, out_lab_nxt;

  // memories and their read registers
  logic [7:0]    pix_mem [CELLS];
  logic [LW-1:0] lab_mem [CELLS];
  logic [EW-1:0] stk_mem [CELLS];
  logic [7:0]    pix_q_r;
  logic [LW-1:0] lab_q_r;
  logic [EW-1:0] stk_q_r;

  logic          pix_we, lab_we, lab_re, stk_we, stk_re;
  logic [AW-1:0] pix_wa, lab_wa, lab_ra, rd_addr;
  logic [LW-1:0] lab_wd;
  logic [AW:0]   depth_m1;

  function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(r * MAX_COLS) + AW'(c);
  endfunction

  // --------------------------------------------------------------------------
  // neighbour of the top entry in its current direction
  // --------------------------------------------------------------------------
  logic          nb_ok;
  logic [RW-1:0] nb_row;
  logic [CW-1:0] nb_col;

  always_comb begin
    nb_ok  = 1'b0;
    nb_row = top_row_r;
    nb_col = top_col_r;
    case (top_dir_r[1:0])
      2'd0: begin
        nb_ok  = (top_row_r != '0);
        nb_row = top_row_r - RW'(1);
      end
      2'd1: begin
        nb_ok  = (16'(top_col_r) + 16'd1 < 16'(cols_r));
        nb_col = top_col_r + CW'(1);
      end
      2'd2: begin
        nb_ok  = (16'(top_row_r) + 16'd1 < 16'(rows_r));
        nb_row = top_row_r + RW'(1);
      end
      default: begin
        nb_ok  = (top_col_r != '0);
        nb_col = top_col_r - CW'(1);
      end
    endcase
  end

  // shared multiplier: pixel*count first, then criterion*count
  logic [7:0]    mul_a;
  logic [SW-1:0] mul_p;
  assign mul_a = (state_r == rgs_pkg::S_FIT1) ? pix_q_r : crit_r;
  assign mul_p = SW'(mul_a) * SW'(count_r);

  // command decode
  logic          in_inside;
  logic [RW-1:0] in_r;
  logic [CW-1:0] in_c;
  logic          accept;
  assign in_inside = ({1'b0, in_row} < rows_r) && ({1'b0, in_col} < cols_r);
  assign in_r      = RW'(in_row);
  assign in_c      = CW'(in_col);
  assign accept    = start && !busy;
  assign depth_m1  = depth_r - (AW+1)'(1);

  // register port
  logic cfg_wr;
  logic [7:0] wval;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign wval   = pwdata[7:0];
  assign pready = 1'b1;
  assign prdata = 32'((paddr[2] == rgs_pkg::REG_COLS) ? cols_r : rows_r);

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    rows_nxt     = rows_r;
    cols_nxt     = cols_r;
    clr_nxt      = clr_r;
    click_nxt    = click_r;
    count_nxt    = count_r;
    sum_nxt      = sum_r;
    prod_nxt     = prod_r;
    absd_nxt     = absd_r;
    crit_nxt     = crit_r;
    depth_nxt    = depth_r;
    top_vld_nxt  = top_vld_r;
    top_row_nxt  = top_row_r;
    top_col_nxt  = top_col_r;
    top_dir_nxt  = top_dir_r;
    tgt_row_nxt  = tgt_row_r;
    tgt_col_nxt  = tgt_col_r;
    ctr_lab_nxt  = ctr_lab_r;
    bnd_nxt      = bnd_r;
    out_valid_nxt = 1'b0;
    out_bnd_nxt  = out_bnd_r;
    out_size_nxt = out_size_r;
    out_lab_nxt  = out_lab_r;
    pix_we = 1'b0;
    pix_wa = addr_of(in_r, in_c);
    lab_we = 1'b0;
    lab_wa = clr_r;
    lab_wd = '0;
    lab_re = 1'b0;
    rd_addr = addr_of(in_r, in_c);
    stk_we = 1'b0;
    stk_re = 1'b0;

    if (cfg_wr) begin
      if (paddr[2] == rgs_pkg::REG_ROWS) begin
        rows_nxt = (wval == 8'd0) ? 8'd1 : ((32'(wval) > MAX_ROWS) ? 8'(MAX_ROWS) : wval);
      end else begin
        cols_nxt = (wval == 8'd0) ? 8'd1 : ((32'(wval) > MAX_COLS) ? 8'(MAX_COLS) : wval);
      end
    end

    case (state_r)
      rgs_pkg::S_CLEAR: begin
        lab_we = 1'b1;
        clr_nxt = clr_r + AW'(1);
        if (32'(clr_r) == CELLS - 1) state_nxt = rgs_pkg::S_IDLE;
      end
      rgs_pkg::S_IDLE: begin
        if (accept) begin
          out_bnd_nxt  = 1'b0;
          out_size_nxt = '0;
          out_lab_nxt  = '0;
          top_row_nxt  = in_r;
          top_col_nxt  = in_c;
          tgt_row_nxt  = in_r;
          tgt_col_nxt  = in_c;
          crit_nxt     = in_criterion;
          case (in_action)
            rgs_pkg::ACT_LOAD: begin
              pix_we = in_inside;
              out_valid_nxt = 1'b1;
            end
            rgs_pkg::ACT_CLICK: begin
              if (32'(click_r) < MAX_CLICKS) begin
                click_nxt = click_r + LW'(1);
                if (in_inside) begin
                  lab_re      = 1'b1;
                  count_nxt   = '0;
                  sum_nxt     = '0;
                  depth_nxt   = '0;
                  top_vld_nxt = 1'b0;
                  state_nxt   = rgs_pkg::S_SEED;
                end else begin
                  out_valid_nxt = 1'b1;
                end
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            rgs_pkg::ACT_CHECK: begin
              if (in_inside) begin
                lab_re    = 1'b1;
                bnd_nxt   = 1'b0;
                state_nxt = rgs_pkg::S_CK_CTR;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      rgs_pkg::S_SEED: begin
        if (lab_q_r != '0) begin
          out_valid_nxt = 1'b1;
          state_nxt = rgs_pkg::S_IDLE;
        end else begin
          state_nxt = rgs_pkg::S_CONQ;
        end
      end
      rgs_pkg::S_CONQ: begin
        lab_we = 1'b1;
        lab_wa = addr_of(tgt_row_r, tgt_col_r);
        lab_wd = click_r;
        count_nxt = count_r + NW'(1);
        sum_nxt   = sum_r + SW'(pix_q_r);
        if (top_vld_r) begin
          stk_we    = 1'b1;
          depth_nxt = depth_r + (AW+1)'(1);
        end
        top_vld_nxt = 1'b1;
        top_row_nxt = tgt_row_r;
        top_col_nxt = tgt_col_r;
        top_dir_nxt = '0;
        state_nxt   = rgs_pkg::S_STEP;
      end
      rgs_pkg::S_STEP: begin
        if (top_dir_r == rgs_pkg::DIR_DONE) begin
          if (depth_r == '0) begin
            out_valid_nxt = 1'b1;
            out_size_nxt  = 15'(count_r);
            out_lab_nxt   = 8'(click_r);
            state_nxt     = rgs_pkg::S_IDLE;
          end else begin
            stk_re    = 1'b1;
            depth_nxt = depth_m1;
            state_nxt = rgs_pkg::S_POP;
          end
        end else begin
          top_dir_nxt = top_dir_r + 3'd1;
          if (nb_ok) begin
            lab_re      = 1'b1;
            rd_addr     = addr_of(nb_row, nb_col);
            tgt_row_nxt = nb_row;
            tgt_col_nxt = nb_col;
            state_nxt   = rgs_pkg::S_NB_EV;
          end
        end
      end
      rgs_pkg::S_POP: begin
        top_row_nxt = stk_q_r[EW-1 -: RW];
        top_col_nxt = stk_q_r[CW+2 -: CW];
        top_dir_nxt = stk_q_r[2:0];
        state_nxt   = rgs_pkg::S_STEP;
      end
      rgs_pkg::S_NB_EV: begin
        state_nxt = (lab_q_r != '0) ? rgs_pkg::S_STEP : rgs_pkg::S_FIT1;
      end
      rgs_pkg::S_FIT1: begin
        prod_nxt  = mul_p;
        state_nxt = rgs_pkg::S_FIT2;
      end
      rgs_pkg::S_FIT2: begin
        absd_nxt  = (prod_r >= sum_r) ? (prod_r - sum_r) : (sum_r - prod_r);
        prod_nxt  = mul_p;
        state_nxt = rgs_pkg::S_FIT3;
      end
      rgs_pkg::S_FIT3: begin
        state_nxt = (absd_r <= prod_r) ? rgs_pkg::S_CONQ : rgs_pkg::S_STEP;
      end
      rgs_pkg::S_CK_CTR: begin
        ctr_lab_nxt = lab_q_r;
        top_dir_nxt = '0;
        state_nxt   = rgs_pkg::S_CK_RD;
      end
      rgs_pkg::S_CK_RD: begin
        if (top_dir_r == rgs_pkg::DIR_DONE) begin
          out_valid_nxt = 1'b1;
          out_bnd_nxt   = bnd_r;
          out_lab_nxt   = 8'(ctr_lab_r);
          state_nxt     = rgs_pkg::S_IDLE;
        end else begin
          top_dir_nxt = top_dir_r + 3'd1;
          if (nb_ok) begin
            lab_re    = 1'b1;
            rd_addr   = addr_of(nb_row, nb_col);
            state_nxt = rgs_pkg::S_CK_EV;
          end
        end
      end
      rgs_pkg::S_CK_EV: begin
        if (lab_q_r != ctr_lab_r) bnd_nxt = 1'b1;
        state_nxt = rgs_pkg::S_CK_RD;
      end
      default: state_nxt = rgs_pkg::S_IDLE;
    endcase
  end

  assign lab_ra = rd_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rgs_pkg::S_CLEAR;
      rows_r      <= ROWS_RST;
      cols_r      <= COLS_RST;
      clr_r       <= '0;
      click_r     <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      depth_r     <= '0;
      top_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      clr_r       <= clr_nxt;
      click_r     <= click_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      depth_r     <= depth_nxt;
      top_vld_r   <= top_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    absd_r     <= absd_nxt;
    crit_r     <= crit_nxt;
    top_row_r  <= top_row_nxt;
    top_col_r  <= top_col_nxt;
    top_dir_r  <= top_dir_nxt;
    tgt_row_r  <= tgt_row_nxt;
    tgt_col_r  <= tgt_col_nxt;
    ctr_lab_r  <= ctr_lab_nxt;
    bnd_r      <= bnd_nxt;
    out_bnd_r  <= out_bnd_nxt;
    out_size_r <= out_size_nxt;
    out_lab_r  <= out_lab_nxt;
  end

  // pixel memory: load writes, reads alongside the label reads
  always_ff @(posedge clk) begin
    if (pix_we) pix_mem[pix_wa] <= in_pixel_value;
    if (lab_re) pix_q_r <= pix_mem[rd_addr];
  end

  // label memory
  always_ff @(posedge clk) begin
    if (lab_we) lab_mem[lab_wa] <= lab_wd;
    if (lab_re) lab_q_r <= lab_mem[lab_ra];
  end

  // walk stack: entries below the top, which is kept in registers
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[depth_r[AW-1:0]] <= {top_row_r, top_col_r, top_dir_r};
    if (stk_re) stk_q_r <= stk_mem[depth_m1[AW-1:0]];
  end

  assign busy             = (state_r != rgs_pkg::S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_boundary     = out_bnd_r;
  assign out_region_size  = out_size_r;
  assign out_region_label = out_lab_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rgs_pkg::S_STEP && top_dir_r == rgs_pkg::DIR_DONE && depth_r == '0)
    |=> out_valid)
    else $error("walk finished without a result beat");

  a_conq_label: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rgs_pkg::S_CONQ) |-> (click_r != '0))
    else $error("conquer with zero label");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    32'(depth_r) < CELLS)
    else $error("walk stack overflow");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result beat without an item");

endmodule

[dv/tb_region_growing_segmenter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_region_growing_segmenter - self-checking bench for the region segmenter
// Loads small images at several register settings, then fires directed and
// random load/click/check beats; a scoreboard predicts each result beat.
// ----------------------------------------------------------------------------
module tb_region_growing_segmenter;

  localparam int          NROWS    = 128;
  localparam int          NCOLS    = 128;
  localparam int          NCLICKS  = 255;
  localparam int          NCELLS   = NROWS * NCOLS;
  localparam logic [1:0]  ACT_NONE = 2'd3;  // unused action code
  localparam int          LIMIT    = 10000000;

  typedef struct packed {
    logic        bnd;
    logic [14:0] size;
    logic [7:0]  label;
  } seg_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: private copy of image, labels and registers; predicts one
  // result beat per accepted command and matches beats in order.
  // --------------------------------------------------------------------------
  class seg_scoreboard;
    bit [7:0]    pix [NCELLS];
    bit [7:0]    lab [NCELLS];
    int          walk_pos [NCELLS];
    int          walk_dir [NCELLS];
    int          rows = NROWS;
    int          cols = NCOLS;
    int          clicks;
    longint      rsum;
    longint      rcnt;
    seg_result_t pending[$];
    int          fails;

    function void set_dim(logic idx, logic [31:0] v);
      int d;
      int dmax;
      d = v[7:0];
      dmax = (idx == rgs_pkg::REG_ROWS) ? NROWS : NCOLS;
      if (d == 0) d = 1;
      if (d > dmax) d = dmax;
      if (idx == rgs_pkg::REG_ROWS) rows = d;
      else cols = d;
    endfunction

    function bit step_to(int r, int c, int d, output int nr, output int nc);
      nr = r;
      nc = c;
      case (d)
        0: begin if (r == 0) return 0; nr = r - 1; end
        1: begin if (c + 1 >= cols) return 0; nc = c + 1; end
        2: begin if (r + 1 >= rows) return 0; nr = r + 1; end
        default: begin if (c == 0) return 0; nc = c - 1; end
      endcase
      return 1;
    endfunction

    function void take(int p, inout int sp);
      rcnt++;
      rsum += pix[p];
      lab[p] = 8'(clicks);
      walk_pos[sp] = p;
      walk_dir[sp] = 0;
      sp++;
    endfunction

    // depth-first growth, exact mean test |p*n - sum| <= crit*n
    function void grow(int seed, int crit);
      int sp, d, p, nr, nc, np;
      longint diff;
      sp = 0;
      rsum = 0;
      rcnt = 0;
      take(seed, sp);
      while (sp > 0) begin
        d = walk_dir[sp-1];
        if (d >= 4) begin
          sp--;
          continue;
        end
        walk_dir[sp-1] = d + 1;
        p = walk_pos[sp-1];
        if (!step_to(p / NCOLS, p % NCOLS, d, nr, nc)) continue;
        np = nr * NCOLS + nc;
        if (lab[np] != 0) continue;
        diff = longint'(pix[np]) * rcnt - rsum;
        if (diff < 0) diff = -diff;
        if (diff > longint'(crit) * rcnt) continue;
        if (sp >= NCELLS) continue;
        take(np, sp);
      end
    endfunction

    function void note_item(logic [1:0] act, logic [6:0] r, logic [6:0] c,
                            logic [7:0] v, logic [7:0] crit);
      seg_result_t e;
      bit          in_img;
      int          p, nr, nc;
      e = '0;
      in_img = (r < rows) && (c < cols);
      p = in_img ? r * NCOLS + c : 0;
      case (act)
        rgs_pkg::ACT_LOAD: if (in_img) pix[p] = v;
        rgs_pkg::ACT_CLICK: begin
          if (clicks < NCLICKS) begin
            clicks++;
            if (in_img && lab[p] == 0) begin
              grow(p, crit);
              e.size  = rcnt[14:0];
              e.label = clicks[7:0];
            end
          end
        end
        rgs_pkg::ACT_CHECK: begin
          if (in_img) begin
            e.label = lab[p];
            for (int d = 0; d < 4; d++)
              if (step_to(r, c, d, nr, nc) && lab[nr*NCOLS+nc] != lab[p]) e.bnd = 1;
          end
        end
        default: ;
      endcase
      pending.push_back(e);
    endfunction

    function void check_result(seg_result_t got);
      seg_result_t e;
      if (pending.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result beat %p", got);
        return;
      end
      e = pending.pop_front();
      if (e !== got) begin
        fails++;
        if (fails <= 10) $display("mismatch: exp bnd=%0d size=%0d label=%0d, got %0d %0d %0d",
                                  e.bnd, e.size, e.label, got.bnd, got.size, got.label);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_action;
  logic [6:0]  in_row;
  logic [6:0]  in_col;
  logic [7:0]  in_pixel_value;
  logic [7:0]  in_criterion;
  logic        out_valid;
  logic        out_boundary;
  logic [14:0] out_region_size;
  logic [7:0]  out_region_label;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  seg_scoreboard sb = new();
  int            cycles = 0;
  int            burst_left;
  bit            no_idle;   // phases that run back-to-back beats

  region_growing_segmenter dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result beats cannot be held off: take every strobed beat
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result({out_boundary, out_region_size, out_region_label});
  end

  // APB write: setup then access; pready is always high
  task automatic write_reg(logic idx, logic [7:0] v);
    logic [31:0] d;
    d = {$urandom} ;
    d[7:0] = v;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_dim(idx, d);
  endtask

  // one command beat; random bursts and gaps on the sender side
  task automatic send(logic [1:0] act, logic [6:0] r, logic [6:0] c,
                      logic [7:0] v, logic [7:0] crit);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start          <= 1'b1;
    in_action      <= act;
    in_row         <= r;
    in_col         <= c;
    in_pixel_value <= v;
    in_criterion   <= crit;
    do @(posedge clk); while (busy);
    sb.note_item(act, r, c, v, crit);
  endtask

  // drain all expected beats before touching registers
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // new image size, then write every pixel inside it so no unwritten
  // pixel is ever read by a walk
  task automatic new_image(logic [7:0] rv, logic [7:0] cv);
    int base;
    drain();
    write_reg(rgs_pkg::REG_ROWS, rv);
    write_reg(rgs_pkg::REG_COLS, cv);
    base = $urandom_range(0, 235);
    for (int r = 0; r < sb.rows; r++)
      for (int c = 0; c < sb.cols; c++)
        send(rgs_pkg::ACT_LOAD, 7'(r), 7'(c),
             8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                            : base + $urandom_range(0, 20)),
             8'd0);
  endtask

  task automatic random_items(int n);
    int          k;
    logic [1:0]  act;
    logic [6:0]  r, c;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      act = (k < 25) ? rgs_pkg::ACT_LOAD : (k < 60) ? rgs_pkg::ACT_CLICK :
            (k < 95) ? rgs_pkg::ACT_CHECK : ACT_NONE;
      if ($urandom_range(0, 9) < 8) begin
        r = 7'($urandom_range(0, sb.rows - 1));
        c = 7'($urandom_range(0, sb.cols - 1));
      end else begin
        r = 7'($urandom_range(0, 127));
        c = 7'($urandom_range(0, 127));
      end
      send(act, r, c, 8'($urandom_range(0, 255)),
           8'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 255)));
    end
  endtask

  // clicks until the click budget is spent, a few past it, then checks
  task automatic spend_clicks();
    logic [6:0] r, c;
    while (sb.clicks < NCLICKS + 6) begin
      if (sb.clicks >= NCLICKS) sb.clicks++;   // past the budget: count locally
      r = 7'($urandom_range(0, sb.rows - 1));
      c = 7'($urandom_range(0, sb.cols - 1));
      send(rgs_pkg::ACT_CLICK, r, c, 8'd0, 8'($urandom_range(0, 40)));
    end
    sb.clicks = NCLICKS;
    for (int i = 0; i < 6; i++) begin
      r = 7'($urandom_range(0, sb.rows - 1));
      c = 7'($urandom_range(0, sb.cols - 1));
      send(rgs_pkg::ACT_CHECK, r, c, 8'd0, 8'd0);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_action      = rgs_pkg::ACT_LOAD;
    in_row         = '0;
    in_col         = '0;
    in_pixel_value = '0;
    in_criterion   = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    burst_left     = 0;
    no_idle        = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: 4x4 image, extreme pixel values and criteria
    new_image(8'd4, 8'd4);
    send(rgs_pkg::ACT_LOAD, 0, 0, 8'd0, 8'd0);
    send(rgs_pkg::ACT_LOAD, 3, 3, 8'd255, 8'd0);
    send(rgs_pkg::ACT_LOAD, 7'd127, 7'd127, 8'd9, 8'd0);  // outside: ignored
    send(rgs_pkg::ACT_CHECK, 0, 0, 8'd0, 8'd0);           // all unlabelled
    send(rgs_pkg::ACT_CLICK, 0, 0, 8'd0, 8'd0);           // exact-match region
    send(rgs_pkg::ACT_CLICK, 0, 0, 8'd0, 8'd255);         // seed already labelled
    send(rgs_pkg::ACT_CLICK, 7'd100, 7'd2, 8'd0, 8'd255); // seed outside image
    send(rgs_pkg::ACT_CLICK, 3, 3, 8'd0, 8'd255);         // swallows the rest
    send(rgs_pkg::ACT_CHECK, 0, 0, 8'd0, 8'd0);
    send(rgs_pkg::ACT_CHECK, 3, 3, 8'd0, 8'd0);
    send(rgs_pkg::ACT_CHECK, 1, 2, 8'd0, 8'd0);
    send(rgs_pkg::ACT_CHECK, 7'd4, 7'd0, 8'd0, 8'd0);     // outside: zeros
    send(ACT_NONE, 2, 2, 8'd255, 8'd255);
    send(ACT_NONE, 7'd127, 7'd127, 8'd255, 8'd255);

    new_image(8'd8, 8'd8);
    random_items(60);

    // register extremes: rows 0 clamps to 1, cols 200 clamps to 128
    new_image(8'd0, 8'd200);
    no_idle = 1'b1;
    random_items(40);
    no_idle = 1'b0;

    // small image, then use up the click budget
    new_image(8'd3, 8'd5);
    spend_clicks();

    drain();
    repeat (20) @(posedge clk);
    if (sb.fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[region_growing_segmenter.f]
src/rgs_pkg.sv
src/region_growing_segmenter.sv
dv/tb_region_growing_segmenter.sv
